// ===== rtl/core/bpa_pkg.sv =====
// Shared types, codes and layout helpers for the buddy page allocator.
package bpa_pkg;

   localparam int MAX_ORDER_DEF = 10;
   localparam int WORD_W        = 32;
   localparam int LOG_WORD_W    = 5;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_OOM   = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_AFIND,
      ST_ADDR,
      ST_RD,
      ST_MOD,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      MODE_INIT,
      MODE_ALLOC,
      MODE_SPLIT,
      MODE_FREE
   } mode_type;

   function automatic int bpa_order_words(input int max_order, input int order);
      int res;
      if (max_order - order >= LOG_WORD_W) begin
         res = 1 << (max_order - order - LOG_WORD_W);
      end else begin
         res = 1;
      end
      return res;
   endfunction

   function automatic int bpa_word_base(input int max_order, input int order);
      int sum;
      sum = 0;
      for (int k = 0; k < order; k++) begin
         sum += bpa_order_words(max_order, k);
      end
      return sum;
   endfunction

endpackage

// ===== rtl/core/buddy_page_allocator_top.sv =====
// Buddy page allocator: sequencer, bitmap word memory and per-word nonempty flags.
//
// Requests arrive on req_ (op, page) and each yields exactly one beat on rsp_
// (alloc_page, status). The last used page comes in on csr_ and is applied at
// the next init op. req_tready is high only while the sequencer is idle; a
// finished response sits in the rsp_ output register, so a new request is
// taken while the receiver stalls, and the sequencer waits in its response
// state only if that register is still full.
// Every bitmap access is a read-modify-write through the single word memory
// port: address, read, modify/write.
//   init : walks every order from MAX_ORDER down, one access per block freed
//   alloc: out of memory answers at once, else one access plus one per split order
//   free : out of range answers at once, else one access per order walked
//   unused op: goes straight to the response
// The order search of alloc is one priority pick over the nonempty flags.
// Reset clears the flags, so the map reads as empty without a clearing pass;
// init clears them the same way.
module buddy_page_allocator_top #(
   parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op[1:0], page[11:2], zero[15:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // alloc_page[9:0], status[11:10], zero[15:12]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);
   import bpa_pkg::*;

   localparam int PW = MAX_ORDER;
   localparam int OW = $clog2(MAX_ORDER + 1);
   localparam int DW = bpa_word_base(MAX_ORDER, MAX_ORDER + 1);
   localparam int AW = (DW > 1) ? $clog2(DW) : 1;
   localparam int SW = ((MAX_ORDER > 10) ? MAX_ORDER : 10) + 2;
   localparam int XW = PW + AW + LOG_WORD_W;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [PW-1:0]     tgt_ff, tgt_in;
   logic [PW-1:0]     start_ff, start_in;
   logic [SW-1:0]     lowest_ff, lowest_in;
   logic [AW-1:0]     waddr_ff, waddr_in;
   logic [4:0]        bit_ff, bit_in;
   logic [9:0]        res_page_ff, res_page_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [DW-1:0]     flag_ff;
   logic [WORD_W-1:0] rd_ff;
   logic [WORD_W-1:0] mem [DW];
   logic [9:0]        lup_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   logic [AW-1:0]     wbase [MAX_ORDER+1];
   logic              accept, rsp_load, range_err, init_take, merge, mod_done;
   logic              wr_en, flag_clr;
   logic [WORD_W-1:0] wdata, eff;
   logic [1:0]        req_op;
   logic [9:0]        req_page;
   logic [XW-1:0]     blkx, ablk;
   logic [AW-1:0]     calc_addr, off;
   logic [4:0]        calc_bit, lo_bit;
   logic [AW-1:0]     lo_word;
   logic              any_flag;
   logic [OW-1:0]     lo_ord;
   logic [PW-1:0]     alloc_start, half, own;
   logic [SW-1:0]     init_start;

   for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_base
      assign wbase[g] = AW'(bpa_word_base(MAX_ORDER, g));
   end

   assign req_op     = req_tdata[1:0];
   assign req_page   = req_tdata[11:2];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign range_err  = SW'(req_page) >= (SW'(1) << MAX_ORDER);
   assign init_start = ((SW'(lup_ff) >> ord_ff) + SW'(1)) << ord_ff;
   assign init_take  = init_start < lowest_ff;

   assign blkx      = XW'(tgt_ff) >> ord_ff;
   assign calc_addr = wbase[ord_ff] + AW'(blkx >> LOG_WORD_W);
   assign calc_bit  = blkx[4:0];

   assign eff         = flag_ff[waddr_ff] ? rd_ff : '0;
   assign off         = waddr_ff - wbase[ord_ff];
   assign ablk        = XW'({off, lo_bit}) << ord_ff;
   assign alloc_start = PW'(ablk);
   assign half        = PW'(XW'(1) << (ord_ff - OW'(1)));
   assign own         = PW'(XW'(1) << ord_ff);
   assign merge       = (mode_ff == MODE_FREE) && (ord_ff != OW'(MAX_ORDER))
                        && eff[bit_ff ^ 5'd1];

   always_comb begin
      lo_bit = '0;
      for (int k = WORD_W - 1; k >= 0; k--) begin
         if (eff[k]) lo_bit = 5'(k);
      end
   end

   always_comb begin
      lo_word  = '0;
      any_flag = |flag_ff;
      for (int k = DW - 1; k >= 0; k--) begin
         if (flag_ff[k]) lo_word = AW'(k);
      end
      lo_ord = '0;
      for (int k = 0; k <= MAX_ORDER; k++) begin
         if (lo_word >= wbase[k]) lo_ord = OW'(k);
      end
   end

   always_comb begin
      priority case (mode_ff)
         MODE_FREE: mod_done = !merge;
         default:   mod_done = (ord_ff == '0);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_op)
                  OP_INIT:  state_in = ST_INIT;
                  OP_ALLOC: state_in = ST_AFIND;
                  OP_FREE:  state_in = range_err ? ST_RESP : ST_ADDR;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_INIT: begin
            if (init_take) state_in = ST_ADDR;
            else if (ord_ff == '0) state_in = ST_RESP;
         end
         ST_AFIND: state_in = any_flag ? ST_RD : ST_RESP;
         ST_ADDR:  state_in = ST_RD;
         ST_RD:    state_in = ST_MOD;
         ST_MOD: begin
            if (mod_done) state_in = ST_RESP;
            else if (mode_ff == MODE_INIT) state_in = ST_INIT;
            else state_in = ST_ADDR;
         end
         ST_RESP: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mode_in       = mode_ff;
      ord_in        = ord_ff;
      tgt_in        = tgt_ff;
      start_in      = start_ff;
      lowest_in     = lowest_ff;
      waddr_in      = waddr_ff;
      bit_in        = bit_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wdata         = eff;
      flag_clr      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_page_in   = '0;
               res_status_in = STATUS_OK;
               priority case (req_op)
                  OP_INIT: begin
                     flag_clr  = 1'b1;
                     ord_in    = OW'(MAX_ORDER);
                     lowest_in = SW'(1) << MAX_ORDER;
                  end
                  OP_ALLOC: mode_in = MODE_ALLOC;
                  OP_FREE: begin
                     if (range_err) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        mode_in = MODE_FREE;
                        tgt_in  = PW'(req_page);
                        ord_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            if (init_take) begin
               lowest_in = init_start;
               tgt_in    = PW'(init_start);
               mode_in   = MODE_INIT;
            end else if (ord_ff != '0) begin
               ord_in = ord_ff - OW'(1);
            end
         end
         ST_AFIND: begin
            if (any_flag) begin
               waddr_in = lo_word;
               ord_in   = lo_ord;
            end else begin
               res_status_in = STATUS_OOM;
            end
         end
         ST_ADDR: begin
            waddr_in = calc_addr;
            bit_in   = calc_bit;
         end
         ST_RD: ;
         ST_MOD: begin
            wr_en = 1'b1;
            unique case (mode_ff)
               MODE_INIT: begin
                  wdata = eff | (WORD_W'(1) << bit_ff);
                  if (ord_ff != '0) ord_in = ord_ff - OW'(1);
               end
               MODE_ALLOC: begin
                  wdata       = eff & ~(WORD_W'(1) << lo_bit);
                  start_in    = alloc_start;
                  res_page_in = 10'(alloc_start);
                  if (ord_ff != '0) begin
                     tgt_in  = alloc_start | half;
                     ord_in  = ord_ff - OW'(1);
                     mode_in = MODE_SPLIT;
                  end
               end
               MODE_SPLIT: begin
                  wdata = eff | (WORD_W'(1) << bit_ff);
                  if (ord_ff != '0) begin
                     tgt_in = start_ff | half;
                     ord_in = ord_ff - OW'(1);
                  end
               end
               MODE_FREE: begin
                  if (merge) begin
                     wdata  = eff & ~(WORD_W'(1) << (bit_ff ^ 5'd1));
                     tgt_in = tgt_ff & ~own;
                     ord_in = ord_ff + OW'(1);
                  end else begin
                     wdata = eff | (WORD_W'(1) << bit_ff);
                  end
               end
               default: ;
            endcase
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[waddr_ff];
      if (wr_en) mem[waddr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= '0;
         lup_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (flag_clr) flag_ff <= '0;
         else if (wr_en) flag_ff[waddr_ff] <= |wdata;
         if (csr_valid) lup_ff <= csr_data;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      ord_ff        <= ord_in;
      tgt_ff        <= tgt_in;
      start_ff      <= start_in;
      lowest_ff     <= lowest_in;
      waddr_ff      <= waddr_in;
      bit_ff        <= bit_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      if (rsp_load) rsp_data_ff <= {4'b0, res_status_ff, res_page_ff};
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken but sequencer stayed idle");

   a_oom_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[11:10] == STATUS_OOM) |-> (rsp_data_ff[9:0] == '0))
      else $error("out of memory beat carries a page");

   a_empty_map_oom: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AFIND) && (flag_ff == '0) |=>
      (state_ff == ST_RESP) && (res_status_ff == STATUS_OOM))
      else $error("empty map did not report out of memory");
`endif

endmodule

// ===== sim/buddy_page_allocator_checker.sv =====
// Checker for the buddy page allocator: tracks csr/req/rsp beats, predicts, compares.
module buddy_page_allocator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [9:0]  csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int ORD   = MAX_ORDER_DEF;
   localparam int PAGES = 1 << ORD;
   localparam int DEPTH = (2 << ORD) - 1;

   typedef struct packed {
      logic [9:0] page;
      logic [1:0] status;
   } alloc_rsp_type;

   logic [9:0]    kernel_top;
   bit            bitmap[DEPTH];
   alloc_rsp_type rsp_queue[$];

   function automatic int ofs(int o);
      return (2 << ORD) - (2 << (ORD - o));
   endfunction

   function automatic alloc_rsp_type serve_request(logic [1:0] op, logic [9:0] pg);
      alloc_rsp_type r;
      int lowest, st, s, o, bud;
      bit found;
      r = '0;
      if (op == OP_INIT) begin
         foreach (bitmap[i]) bitmap[i] = 1'b0;
         lowest = PAGES;
         for (o = ORD; o >= 0; o--) begin
            st = ((int'(kernel_top) >> o) + 1) << o;
            if (st < lowest) begin
               bitmap[ofs(o) + (st >> o)] = 1'b1;
               lowest = st;
            end
         end
      end else if (op == OP_ALLOC) begin
         found = 1'b0;
         for (o = 0; o <= ORD && !found; o++) begin
            for (int b = 0; b < (PAGES >> o) && !found; b++) begin
               if (bitmap[ofs(o) + b]) begin
                  found = 1'b1;
                  bitmap[ofs(o) + b] = 1'b0;
                  st = b << o;
                  for (int j = o; j > 0; j--)
                     bitmap[ofs(j - 1) + ((st + (1 << (j - 1))) >> (j - 1))] = 1'b1;
                  r.page = st[9:0];
               end
            end
         end
         if (!found) r.status = STATUS_OOM;
      end else if (op == OP_FREE) begin
         s = int'(pg);
         o = 0;
         while (o < ORD) begin
            bud = s ^ (1 << o);
            if (!bitmap[ofs(o) + (bud >> o)]) break;
            bitmap[ofs(o) + (bud >> o)] = 1'b0;
            s &= ~(1 << o);
            o++;
         end
         bitmap[ofs(o) + (s >> o)] = 1'b1;
      end
      return r;
   endfunction

   assign pending = rsp_queue.size();

   always @(posedge clock) begin
      alloc_rsp_type e, a;
      if (reset) begin
         kernel_top <= '0;
         foreach (bitmap[i]) bitmap[i] = 1'b0;
         rsp_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) kernel_top <= csr_data;
         if (req_tvalid && req_tready)
            rsp_queue.push_back(serve_request(req_tdata[1:0], req_tdata[11:2]));
         if (rsp_tvalid && rsp_tready) begin
            a.page   = rsp_tdata[9:0];
            a.status = rsp_tdata[11:10];
            if (rsp_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected rsp beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               e = rsp_queue.pop_front();
               if (e != a || rsp_tdata[15:12] != 4'd0) begin
                  if (fail_count < 10)
                     $display("mismatch: exp page %0d status %0d, got page %0d status %0d",
                              e.page, e.status, a.page, a.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/buddy_page_allocator_top_tb.sv =====
// Testbench top for the buddy page allocator: stimulus, idling phases and verdict.
module buddy_page_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam logic [1:0] OP_RSVD = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid, rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 0, csr_ready;
   logic [9:0]  csr_data = '0;
   int          fail_count, pending;
   int          send_idle, recv_stall;
   longint      cycles = 0;

   buddy_page_allocator_top u_dut (.*);
   buddy_page_allocator_checker u_chk (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall);

   task automatic send_req(logic [1:0] op, logic [9:0] pg);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'b0, pg, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [9:0] v);
      drain();
      csr_valid <= 1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_req();
      int k;
      k = $urandom_range(99);
      if (k < 4) send_req(OP_INIT, 10'($urandom));
      else if (k < 50) send_req(OP_ALLOC, 10'($urandom));
      else if (k < 97)
         send_req(OP_FREE, 10'((k & 1) ? $urandom_range(15) : $urandom));
      else send_req(OP_RSVD, 10'($urandom));
   endtask

   initial begin
      logic [9:0] tops[6];
      tops = '{10'd0, 10'd1023, 10'd1000, 10'd511, 10'd1021, 10'd0};
      send_idle = 0;
      recv_stall = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_FREE, 10'd5);
      send_req(OP_FREE, 10'd5);
      send_req(OP_FREE, 10'd4);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_RSVD, 10'h3ff);
      send_req(OP_INIT, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_FREE, 10'd1);
      send_req(OP_FREE, 10'd1023);
      send_req(OP_FREE, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      write_csr(10'd1023);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_INIT, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_FREE, 10'h2aa);
      send_req(OP_FREE, 10'h155);
      send_req(OP_ALLOC, 10'd0);
      send_req(OP_ALLOC, 10'd0);
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 85; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 85; end
            default: begin send_idle = 32; recv_stall = 32; end
         endcase
         write_csr(ph == 5 ? 10'($urandom_range(1023)) : tops[ph]);
         send_req(OP_INIT, 10'd0);
         for (int i = 0; i < 90; i++) random_req();
      end
      drain();
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/bpa_pkg.sv
rtl/core/buddy_page_allocator_top.sv
sim/buddy_page_allocator_checker.sv
sim/buddy_page_allocator_top_tb.sv
